/* hw/rtl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_SYNC(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

/* hw/rtl/bcm_pkg.sv */
`default_nettype none
package bcm_pkg;

    localparam int MAX_TERMS_DEF = 4;
    localparam int SLOT_LIMIT    = 4;
    localparam int CFG_W         = 39;
    localparam int CFG_IDX_W     = 3;
    localparam int COUNT_W       = 3;
    localparam int HITS_W        = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TERM0      = 3'd1;

    // P register flag positions
    localparam logic [7:0] FLAG_N = 8'h80;
    localparam logic [7:0] FLAG_V = 8'h40;
    localparam logic [7:0] FLAG_B = 8'h10;
    localparam logic [7:0] FLAG_D = 8'h08;
    localparam logic [7:0] FLAG_I = 8'h04;
    localparam logic [7:0] FLAG_Z = 8'h02;
    localparam logic [7:0] FLAG_C = 8'h01;

    typedef enum logic [3:0] {
        SRC_A      = 4'd0,
        SRC_X      = 4'd1,
        SRC_Y      = 4'd2,
        SRC_SP     = 4'd3,
        SRC_P      = 4'd4,
        SRC_N      = 4'd5,
        SRC_V      = 4'd6,
        SRC_B      = 4'd7,
        SRC_D      = 4'd8,
        SRC_I      = 4'd9,
        SRC_Z      = 4'd10,
        SRC_C      = 4'd11,
        SRC_VALUE  = 4'd12,
        SRC_MEM    = 4'd13,
        SRC_RASTER = 4'd14,
        SRC_CYCLE  = 4'd15
    } t_src;

    typedef enum logic [2:0] {
        OP_EQ       = 3'd0,
        OP_NE       = 3'd1,
        OP_LT       = 3'd2,
        OP_GT       = 3'd3,
        OP_LE       = 3'd4,
        OP_GE       = 3'd5,
        OP_ANY_SET  = 3'd6,
        OP_ALL_CLR  = 3'd7
    } t_op;

    typedef struct packed {
        t_op         op;
        t_src        src;
        logic [15:0] addr;
        logic [15:0] imm;
    } t_term;

    typedef struct packed {
        logic [7:0]  reg_a;
        logic [7:0]  reg_x;
        logic [7:0]  reg_y;
        logic [7:0]  stack_ptr;
        logic [7:0]  status_flags;
        logic        value_valid;
        logic [15:0] access_value;
        logic [15:0] raster_line;
        logic [15:0] line_cycle;
        logic        mem_valid;
        logic [31:0] mem_bytes;
    } t_in_item;

    typedef struct packed {
        logic              match;
        logic [HITS_W-1:0] term_hits;
    } t_out_item;

endpackage
`default_nettype wire

/* hw/rtl/bcm_cfg_regs.sv */
`default_nettype none
module bcm_cfg_regs #(
    parameter int SLOTS = bcm_pkg::MAX_TERMS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bcm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bcm_pkg::CFG_W-1:0]     i_cfg_wdata,
    output bcm_pkg::t_term                     o_terms [SLOTS],
    output logic [bcm_pkg::COUNT_W-1:0]        o_count
);
    import bcm_pkg::*;

    logic [COUNT_W-1:0] r_count;
    t_term              r_terms [SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int k = 0; k < SLOTS; k++) begin
                r_terms[k] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_TERM_COUNT) begin
                r_count <= i_cfg_wdata[COUNT_W-1:0];
            end
            for (int k = 0; k < SLOTS; k++) begin
                if (i_cfg_idx == CFG_TERM0 + CFG_IDX_W'(k)) begin
                    r_terms[k] <= t_term'(i_cfg_wdata);
                end
            end
        end
    end

    assign o_count = r_count;
    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            o_terms[k] = r_terms[k];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/bcm_term_eval.sv */
`default_nettype none
module bcm_term_eval (
    input  wire bcm_pkg::t_term    i_term,
    input  wire bcm_pkg::t_in_item i_item,
    input  wire logic [7:0]        i_mem_byte,
    output logic                   o_hit
);
    import bcm_pkg::*;

    logic [15:0] v;
    logic        avail;
    logic        cmp;
    logic [7:0]  p;

    assign p = i_item.status_flags;

    always_comb begin
        avail = 1'b1;
        unique case (i_term.src)
            SRC_A:      v = {8'd0, i_item.reg_a};
            SRC_X:      v = {8'd0, i_item.reg_x};
            SRC_Y:      v = {8'd0, i_item.reg_y};
            SRC_SP:     v = {8'd0, i_item.stack_ptr};
            SRC_P:      v = {8'd0, p};
            SRC_N:      v = {15'd0, |(p & FLAG_N)};
            SRC_V:      v = {15'd0, |(p & FLAG_V)};
            SRC_B:      v = {15'd0, |(p & FLAG_B)};
            SRC_D:      v = {15'd0, |(p & FLAG_D)};
            SRC_I:      v = {15'd0, |(p & FLAG_I)};
            SRC_Z:      v = {15'd0, |(p & FLAG_Z)};
            SRC_C:      v = {15'd0, |(p & FLAG_C)};
            SRC_VALUE: begin
                v     = i_item.access_value;
                avail = i_item.value_valid;
            end
            SRC_MEM: begin
                v     = {8'd0, i_mem_byte};
                avail = i_item.mem_valid;
            end
            SRC_RASTER: v = i_item.raster_line;
            SRC_CYCLE:  v = i_item.line_cycle;
            default:    v = i_item.line_cycle;
        endcase
    end

    always_comb begin
        unique case (i_term.op)
            OP_EQ:      cmp = (v == i_term.imm);
            OP_NE:      cmp = (v != i_term.imm);
            OP_LT:      cmp = (v <  i_term.imm);
            OP_GT:      cmp = (v >  i_term.imm);
            OP_LE:      cmp = (v <= i_term.imm);
            OP_GE:      cmp = (v >= i_term.imm);
            OP_ANY_SET: cmp = |(v & i_term.imm);
            OP_ALL_CLR: cmp = ~|(v & i_term.imm);
            default:    cmp = ~|(v & i_term.imm);
        endcase
    end

    // missing value or memory byte fails the term whatever the compare
    assign o_hit = avail & cmp;

endmodule
`default_nettype wire

/* hw/rtl/breakpoint_condition_matcher.sv */
`default_nettype none
// Breakpoint condition matcher: checks one CPU snapshot per transfer against up to four
// configured terms (source, compare op, 16-bit immediate) and returns the AND of the
// enabled terms plus a hit bit per term. A snapshot can be accepted every clock cycle;
// it is captured in an input register, evaluated by one combinational pass through the
// term compare units, and lands in the result register once that register is free or
// being taken; the result is offered from there. While a result waits, one more
// snapshot can sit in the input register; after that the input stalls until the result
// is taken. The user must write terms through the plain write port only while no
// snapshot is in flight; the block itself does not enforce this.
module breakpoint_condition_matcher #(
    parameter int MAX_TERMS = bcm_pkg::MAX_TERMS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bcm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bcm_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire bcm_pkg::t_in_item             i_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output bcm_pkg::t_out_item                 o_out
);
    import bcm_pkg::*;

    localparam int SLOTS = (MAX_TERMS < SLOT_LIMIT) ? MAX_TERMS : SLOT_LIMIT;

    t_term              terms [SLOTS];
    logic [COUNT_W-1:0] count;

    logic        r_s1_valid;
    t_in_item    r_s1_item;
    logic        r_out_valid;
    t_out_item   r_out;
    logic        s1_move;
    logic [HITS_W-1:0] hit_raw;
    t_out_item   n_out;

    bcm_cfg_regs #(.SLOTS(SLOTS)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_terms     (terms),
        .o_count     (count)
    );

    for (genvar k = 0; k < HITS_W; k++) begin : g_term
        if (k < SLOTS) begin : g_on
            bcm_term_eval u_eval (
                .i_term     (terms[k]),
                .i_item     (r_s1_item),
                .i_mem_byte (r_s1_item.mem_bytes[8*k +: 8]),
                .o_hit      (hit_raw[k])
            );
        end else begin : g_off
            assign hit_raw[k] = 1'b0;
        end
    end

    always_comb begin
        logic all_ok;
        all_ok = 1'b1;
        n_out.term_hits = '0;
        for (int k = 0; k < SLOTS; k++) begin
            if (count > COUNT_W'(k)) begin
                n_out.term_hits[k] = hit_raw[k];
                all_ok = all_ok & hit_raw[k];
            end
        end
        n_out.match = all_ok;
    end

    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_item <= i_in;
        end
        if (s1_move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

/* hw/rtl/bcm_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module bcm_checker #(
    parameter int MAX_TERMS = bcm_pkg::MAX_TERMS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bcm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bcm_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_ready,
    input  wire bcm_pkg::t_out_item            o_out
);
    import bcm_pkg::*;

    localparam int SLOTS = (MAX_TERMS < SLOT_LIMIT) ? MAX_TERMS : SLOT_LIMIT;

    logic [COUNT_W-1:0] r_count;
    logic [HITS_W-1:0]  en_mask;

    // shadow of the enabled-term count, seen from the write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we && i_cfg_idx == CFG_TERM_COUNT) begin
            r_count <= i_cfg_wdata[COUNT_W-1:0];
        end
    end

    always_comb begin
        en_mask = '0;
        for (int k = 0; k < SLOTS; k++) begin
            en_mask[k] = (r_count > COUNT_W'(k));
        end
    end

    `ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid)
    `ASSERT_SYNC(a_out_held, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
    `ASSERT_SYNC(a_match_is_and, i_clk, i_rst_n,
        o_out_valid |-> o_out.match == ((o_out.term_hits & en_mask) == en_mask))
    `ASSERT_SYNC(a_disabled_no_hit, i_clk, i_rst_n,
        o_out_valid |-> (o_out.term_hits & ~en_mask) == '0)

endmodule

bind breakpoint_condition_matcher bcm_checker #(.MAX_TERMS(MAX_TERMS)) u_bcm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_idx   (i_cfg_idx),
    .i_cfg_wdata (i_cfg_wdata),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
`default_nettype wire
